// File: rtl/core/mtcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus TCP client framer package
// Types, codes and constants shared by the front, queue and back of the framer.
// ----------------------------------------------------------------------------
package mtcf_pkg;

	localparam int unsigned MAX_PDU_DEFAULT   = 256;
	localparam int unsigned CMD_DEPTH_DEFAULT = 4;

	localparam int unsigned FRAME_LEN   = 12;
	localparam int unsigned COUNT_W     = 9;
	localparam int unsigned HDR_IDX_W   = 3;
	localparam int unsigned FRAME_IDX_W = 4;

	localparam logic [7:0] MBAP_LEN_LO     = 8'd6;
	localparam logic [7:0] EXC_FLAG        = 8'h80;
	localparam logic [7:0] FC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FC_READ_INPUT   = 8'd4;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;

	localparam logic [HDR_IDX_W-1:0] HDR_PROTO_HI = 3'd2;
	localparam logic [HDR_IDX_W-1:0] HDR_PROTO_LO = 3'd3;
	localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI   = 3'd4;
	localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO   = 3'd5;
	localparam logic [HDR_IDX_W-1:0] HDR_UNIT     = 3'd6;

	typedef enum logic [2:0] {
		OP_REQUEST    = 3'd0,
		OP_RX_BYTE    = 3'd1,
		OP_TIMEOUT    = 3'd2,
		OP_CLOSED     = 3'd3,
		OP_LINK_ERROR = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_FRAME_BYTE = 2'd0,
		KIND_PDU_BYTE   = 2'd1,
		KIND_STATUS     = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_ARG    = 3'd1,
		ST_TIMEOUT    = 3'd2,
		ST_CLOSED     = 3'd3,
		ST_LINK_ERROR = 3'd4,
		ST_BAD_HEADER = 3'd5,
		ST_EXCEPTION  = 3'd6,
		ST_BAD_PDU    = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_PDU    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_FRAME  = 2'd0,
		CMD_PDU    = 2'd1,
		CMD_STATUS = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [15:0]        tid;
		logic [7:0]         unit;
		logic [7:0]         func;
		logic [15:0]        addr;
		logic [15:0]        tail;
		logic [7:0]         data;
		logic [COUNT_W-1:0] count;
		logic               fin;
		status_t            status;
		logic [7:0]         exc;
	} cmd_t;

endpackage

// File: rtl/core/mtcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus TCP client framer front end
// Accepts input transactions, tracks the exchange and issues at most one command each.
// ----------------------------------------------------------------------------
module mtcf_front #(
	parameter int unsigned MAX_PDU = mtcf_pkg::MAX_PDU_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [2:0]         op,
	input  logic [7:0]         unit_id,
	input  logic [7:0]         function_code,
	input  logic [15:0]        start_address,
	input  logic [15:0]        quantity,
	input  logic [15:0]        write_value,
	input  logic [7:0]         rx_byte,
	output logic               cmd_push,
	output mtcf_pkg::cmd_t     cmd
);

	import mtcf_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [15:0]            tc_q;
	logic [7:0]             unit_q, func_q;
	logic [HDR_IDX_W-1:0]   hidx_q;
	logic [7:0]             proto_hi_q, proto_lo_q, len_hi_q, len_lo_q;
	logic [COUNT_W-1:0]     rem_q, recv_q;
	logic [7:0]             first_q, second_q;

	op_t                    op_e;
	logic                   supported;
	logic [15:0]            len;
	logic [15:0]            len_m1;
	logic                   hdr_ok;
	logic                   hdr_end;
	logic [COUNT_W-1:0]     recv_n;
	logic [COUNT_W-1:0]     rem_n;
	logic [7:0]             first_n, second_n;
	logic                   cmd_valid;

	assign op_e      = op_t'(op);
	assign supported = (function_code == FC_READ_HOLDING) ||
		(function_code == FC_READ_INPUT) || (function_code == FC_WRITE_SINGLE);
	assign len       = {len_hi_q, len_lo_q};
	assign len_m1    = len - 16'd1;
	assign hdr_ok    = ({proto_hi_q, proto_lo_q} == 16'd0) && (len >= 16'd2) &&
		(rx_byte == unit_q) && (len_m1 <= 16'(MAX_PDU));
	assign hdr_end   = (hidx_q == HDR_UNIT);
	assign recv_n    = recv_q + COUNT_W'(1);
	assign rem_n     = (rem_q != '0) ? rem_q - COUNT_W'(1) : rem_q;
	assign first_n   = (recv_q == COUNT_W'(0)) ? rx_byte : first_q;
	assign second_n  = (recv_q == COUNT_W'(1)) ? rx_byte : second_q;

	always_comb begin
		phase_d = phase_q;
		case (op_e)
			OP_REQUEST: begin
				phase_d = supported ? PH_HEADER : PH_IDLE;
			end
			OP_RX_BYTE: begin
				if (phase_q == PH_HEADER && hdr_end) begin
					phase_d = hdr_ok ? PH_PDU : PH_IDLE;
				end else if (phase_q == PH_PDU && rem_n == '0) begin
					phase_d = PH_IDLE;
				end
			end
			OP_TIMEOUT, OP_CLOSED, OP_LINK_ERROR: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	always_comb begin
		cmd_valid  = 1'b0;
		cmd        = '0;
		cmd.kind   = CMD_STATUS;
		cmd.status = ST_OK;
		cmd.count  = recv_q;
		case (op_e)
			OP_REQUEST: begin
				cmd_valid = 1'b1;
				if (supported) begin
					cmd.kind  = CMD_FRAME;
					cmd.tid   = tc_q + 16'd1;
					cmd.unit  = unit_id;
					cmd.func  = function_code;
					cmd.addr  = start_address;
					cmd.tail  = (function_code == FC_WRITE_SINGLE) ? write_value : quantity;
					cmd.count = '0;
				end else begin
					cmd.status = ST_BAD_ARG;
					cmd.count  = '0;
				end
			end
			OP_RX_BYTE: begin
				if (phase_q == PH_HEADER && hdr_end && !hdr_ok) begin
					cmd_valid  = 1'b1;
					cmd.status = ST_BAD_HEADER;
				end else if (phase_q == PH_PDU) begin
					cmd_valid = 1'b1;
					cmd.kind  = CMD_PDU;
					cmd.data  = rx_byte;
					cmd.count = recv_n;
					cmd.fin   = (rem_n == '0);
					if (first_n == (func_q | EXC_FLAG)) begin
						cmd.status = ST_EXCEPTION;
						cmd.exc    = (recv_n >= COUNT_W'(2)) ? second_n : 8'd0;
					end else if (first_n != func_q) begin
						cmd.status = ST_BAD_PDU;
					end
				end
			end
			OP_TIMEOUT: begin
				cmd_valid  = (phase_q != PH_IDLE);
				cmd.status = ST_TIMEOUT;
			end
			OP_CLOSED: begin
				cmd_valid  = (phase_q != PH_IDLE);
				cmd.status = ST_CLOSED;
			end
			OP_LINK_ERROR: begin
				cmd_valid  = (phase_q != PH_IDLE);
				cmd.status = ST_LINK_ERROR;
			end
			default: begin
				cmd_valid = 1'b0;
			end
		endcase
	end

	assign cmd_push = accept && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tc_q     <= '0;
			unit_q   <= '0;
			func_q   <= '0;
			hidx_q   <= '0;
			rem_q    <= '0;
			recv_q   <= '0;
			first_q  <= '0;
			second_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			if (op_e == OP_REQUEST) begin
				tc_q   <= tc_q + 16'd1;
				recv_q <= '0;
				if (supported) begin
					unit_q   <= unit_id;
					func_q   <= function_code;
					hidx_q   <= '0;
					rem_q    <= '0;
					first_q  <= '0;
					second_q <= '0;
				end
			end else if (op_e == OP_RX_BYTE && phase_q == PH_HEADER) begin
				if (hdr_end) begin
					hidx_q <= '0;
					if (hdr_ok) begin
						rem_q  <= len_m1[COUNT_W-1:0];
						recv_q <= '0;
					end
				end else begin
					hidx_q <= hidx_q + HDR_IDX_W'(1);
				end
			end else if (op_e == OP_RX_BYTE && phase_q == PH_PDU) begin
				recv_q   <= recv_n;
				rem_q    <= rem_n;
				first_q  <= first_n;
				second_q <= second_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op_e == OP_RX_BYTE && phase_q == PH_HEADER) begin
			case (hidx_q)
				HDR_PROTO_HI: proto_hi_q <= rx_byte;
				HDR_PROTO_LO: proto_lo_q <= rx_byte;
				HDR_LEN_HI:   len_hi_q   <= rx_byte;
				HDR_LEN_LO:   len_lo_q   <= rx_byte;
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/core/mtcf_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus TCP client framer command queue
// Short register queue that decouples the front end from the result sequencer.
// ----------------------------------------------------------------------------
module mtcf_cmd_fifo #(
	parameter int unsigned DEPTH = mtcf_pkg::CMD_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  mtcf_pkg::cmd_t wr_data,
	output logic           full,
	output logic           rd_valid,
	output mtcf_pkg::cmd_t rd_data,
	input  logic           rd_en
);

	import mtcf_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: rtl/core/mtcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus TCP client framer result sequencer
// Expands each command into frame bytes, PDU bytes and status results.
// ----------------------------------------------------------------------------
module mtcf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  mtcf_pkg::cmd_t               cmd,
	output logic                         cmd_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [1:0]                   kind,
	output logic [7:0]                   out_byte,
	output logic                         last,
	output logic [2:0]                   status,
	output logic [7:0]                   exc_code,
	output logic [mtcf_pkg::COUNT_W-1:0] pdu_count
);

	import mtcf_pkg::*;

	localparam logic [FRAME_IDX_W-1:0] IDX_LAST = FRAME_IDX_W'(FRAME_LEN - 1);

	cmd_t                   work_q;
	logic                   busy_q;
	logic [FRAME_IDX_W-1:0] idx_q;
	logic                   out_valid_q;

	logic                   out_ready;
	logic                   out_load;
	logic                   gen_final;
	kind_t                  g_kind;
	logic [7:0]             g_byte;
	logic                   g_last;
	status_t                g_status;
	logic [7:0]             g_exc;
	logic [COUNT_W-1:0]     g_count;

	always_comb begin
		g_kind    = KIND_STATUS;
		g_byte    = 8'd0;
		g_last    = 1'b1;
		g_status  = ST_OK;
		g_exc     = 8'd0;
		g_count   = work_q.count;
		gen_final = 1'b1;
		case (work_q.kind)
			CMD_FRAME: begin
				g_kind    = KIND_FRAME_BYTE;
				g_count   = '0;
				g_last    = (idx_q == IDX_LAST);
				gen_final = g_last;
				case (idx_q)
					4'd0:    g_byte = work_q.tid[15:8];
					4'd1:    g_byte = work_q.tid[7:0];
					4'd5:    g_byte = MBAP_LEN_LO;
					4'd6:    g_byte = work_q.unit;
					4'd7:    g_byte = work_q.func;
					4'd8:    g_byte = work_q.addr[15:8];
					4'd9:    g_byte = work_q.addr[7:0];
					4'd10:   g_byte = work_q.tail[15:8];
					4'd11:   g_byte = work_q.tail[7:0];
					default: g_byte = 8'd0;
				endcase
			end
			CMD_PDU: begin
				if (idx_q == '0) begin
					g_kind    = KIND_PDU_BYTE;
					g_byte    = work_q.data;
					g_last    = !work_q.fin;
					gen_final = !work_q.fin;
				end else begin
					g_status = work_q.status;
					g_exc    = work_q.exc;
				end
			end
			CMD_STATUS: begin
				g_status = work_q.status;
			end
			default: begin
				g_kind = KIND_STATUS;
			end
		endcase
	end

	assign out_ready = !out_valid_q || pop;
	assign out_load  = busy_q && out_ready;
	assign cmd_pop   = cmd_valid && (!busy_q || (out_load && gen_final));
	assign empty     = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (cmd_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (out_load) begin
				if (gen_final) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + FRAME_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			work_q <= cmd;
		end
		if (out_load) begin
			kind      <= g_kind;
			out_byte  <= g_byte;
			last      <= g_last;
			status    <= g_status;
			exc_code  <= g_exc;
			pdu_count <= g_count;
		end
	end

endmodule

// File: rtl/core/modbus_tcp_client_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus TCP client framer
// Builds MBAP request frames and checks and unpacks the MBAP response stream.
// ----------------------------------------------------------------------------
// The front end takes one input transaction per cycle whenever full is low and
// turns it into at most one command, which waits in a short queue of
// CMD_DEPTH entries. The back end turns each command into results at one per
// cycle through an output register while results are popped: a request gives
// twelve frame bytes, a final PDU byte gives the byte and then a status, and
// everything else gives a single result. Response bytes and events therefore
// run at one transaction per cycle when results are popped, while each request
// holds the output register for all twelve bytes of its frame. The queue fills
// and raises full when results are not popped or when requests arrive faster
// than the output register can send their frames.
module modbus_tcp_client_framer #(
	parameter int unsigned MAX_PDU   = mtcf_pkg::MAX_PDU_DEFAULT,
	parameter int unsigned CMD_DEPTH = mtcf_pkg::CMD_DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [2:0]                   op,
	input  logic [7:0]                   unit_id,
	input  logic [7:0]                   function_code,
	input  logic [15:0]                  start_address,
	input  logic [15:0]                  quantity,
	input  logic [15:0]                  write_value,
	input  logic [7:0]                   rx_byte,
	output logic                         empty,
	input  logic                         pop,
	output logic [1:0]                   kind,
	output logic [7:0]                   out_byte,
	output logic                         last,
	output logic [2:0]                   status,
	output logic [7:0]                   exc_code,
	output logic [mtcf_pkg::COUNT_W-1:0] pdu_count
);

	import mtcf_pkg::*;

	logic accept;
	logic cmd_push;
	cmd_t cmd_in;
	logic q_valid;
	cmd_t q_data;
	logic q_pop;

	assign accept = push && !full;

	mtcf_front #(
		.MAX_PDU(MAX_PDU)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.op           (op),
		.unit_id      (unit_id),
		.function_code(function_code),
		.start_address(start_address),
		.quantity     (quantity),
		.write_value  (write_value),
		.rx_byte      (rx_byte),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in)
	);

	mtcf_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_valid(q_valid),
		.rd_data (q_data),
		.rd_en   (q_pop)
	);

	mtcf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd      (q_data),
		.cmd_pop  (q_pop),
		.empty    (empty),
		.pop      (pop),
		.kind     (kind),
		.out_byte (out_byte),
		.last     (last),
		.status   (status),
		.exc_code (exc_code),
		.pdu_count(pdu_count)
	);

endmodule

// File: dv/modbus_tcp_client_framer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus TCP client framer checker
// Watches both queue-style channels of the framer. It predicts the request
// frame bytes, PDU bytes and final statuses for each accepted input
// transaction and compares every popped result against the oldest prediction.
// ----------------------------------------------------------------------------
module modbus_tcp_client_framer_checker #(
	parameter int unsigned MAX_PDU = mtcf_pkg::MAX_PDU_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic                         full,
	input  logic [2:0]                   op,
	input  logic [7:0]                   unit_id,
	input  logic [7:0]                   function_code,
	input  logic [15:0]                  start_address,
	input  logic [15:0]                  quantity,
	input  logic [15:0]                  write_value,
	input  logic [7:0]                   rx_byte,
	input  logic                         empty,
	input  logic                         pop,
	input  logic [1:0]                   kind,
	input  logic [7:0]                   out_byte,
	input  logic                         last,
	input  logic [2:0]                   status,
	input  logic [7:0]                   exc_code,
	input  logic [mtcf_pkg::COUNT_W-1:0] pdu_count,
	output int                           fail_count,
	output int                           pending,
	output int                           result_count
);

	import mtcf_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         data;
		logic               fin;
		status_t            st;
		logic [7:0]         exc;
		logic [COUNT_W-1:0] count;
	} framer_result_t;

	framer_result_t expected_results[$];

	logic [15:0]        txn_id;
	logic [7:0]         req_unit;
	logic [7:0]         req_func;
	phase_t             phase;
	logic [2:0]         hdr_idx;
	logic [7:0]         hdr_bytes [6];
	logic [COUNT_W-1:0] pdu_left;
	logic [COUNT_W-1:0] pdu_seen;
	logic [7:0]         pdu_first;
	logic [7:0]         pdu_second;

	function automatic framer_result_t make_result(kind_t k, logic [7:0] d, status_t s,
			logic [7:0] e, logic [COUNT_W-1:0] c);
		framer_result_t res;
		res.kind  = k;
		res.data  = d;
		res.fin   = 1'b0;
		res.st    = s;
		res.exc   = e;
		res.count = c;
		return res;
	endfunction

	task automatic predict_framer(input logic [2:0] o, input logic [7:0] u, input logic [7:0] f,
			input logic [15:0] a, input logic [15:0] q, input logic [15:0] v,
			input logic [7:0] r);
		framer_result_t step_q[$];
		logic [95:0]    frame_bits;
		logic [15:0]    tail;
		int unsigned    hdr_proto;
		int unsigned    hdr_len;
		if (o == OP_REQUEST) begin
			txn_id   = txn_id + 16'd1;
			pdu_seen = '0;
			if (f != FC_READ_HOLDING && f != FC_READ_INPUT && f != FC_WRITE_SINGLE) begin
				step_q.push_back(make_result(KIND_STATUS, 8'h00, ST_BAD_ARG, 8'h00, pdu_seen));
				phase = PH_IDLE;
			end else begin
				tail       = (f == FC_WRITE_SINGLE) ? v : q;
				frame_bits = {txn_id, 16'h0000, 8'h00, MBAP_LEN_LO, u, f, a, tail};
				for (int i = 0; i < FRAME_LEN; i++) begin
					step_q.push_back(make_result(KIND_FRAME_BYTE, frame_bits[95 - 8 * i -: 8],
						ST_OK, 8'h00, '0));
				end
				req_unit   = u;
				req_func   = f;
				phase      = PH_HEADER;
				hdr_idx    = '0;
				pdu_left   = '0;
				pdu_first  = 8'h00;
				pdu_second = 8'h00;
			end
		end else if (phase == PH_IDLE || o > OP_LINK_ERROR) begin
			// Nothing pending, or an undefined operation: the transaction is dropped.
		end else if (o != OP_RX_BYTE) begin
			case (o)
				OP_TIMEOUT: begin
					step_q.push_back(make_result(KIND_STATUS, 8'h00, ST_TIMEOUT, 8'h00, pdu_seen));
				end
				OP_CLOSED: begin
					step_q.push_back(make_result(KIND_STATUS, 8'h00, ST_CLOSED, 8'h00, pdu_seen));
				end
				default: begin
					step_q.push_back(make_result(KIND_STATUS, 8'h00, ST_LINK_ERROR, 8'h00,
						pdu_seen));
				end
			endcase
			phase = PH_IDLE;
		end else if (phase == PH_HEADER) begin
			if (hdr_idx < HDR_UNIT) begin
				hdr_bytes[hdr_idx] = r;
				hdr_idx            = hdr_idx + 3'd1;
			end else begin
				hdr_proto = {hdr_bytes[HDR_PROTO_HI], hdr_bytes[HDR_PROTO_LO]};
				hdr_len   = {hdr_bytes[HDR_LEN_HI], hdr_bytes[HDR_LEN_LO]};
				hdr_idx   = '0;
				if (hdr_proto != 0 || hdr_len < 2 || r != req_unit || hdr_len - 1 > MAX_PDU) begin
					step_q.push_back(make_result(KIND_STATUS, 8'h00, ST_BAD_HEADER, 8'h00,
						pdu_seen));
					phase = PH_IDLE;
				end else begin
					pdu_left = COUNT_W'(hdr_len - 1);
					pdu_seen = '0;
					phase    = PH_PDU;
				end
			end
		end else begin
			if (pdu_seen == 0) begin
				pdu_first = r;
			end else if (pdu_seen == 1) begin
				pdu_second = r;
			end
			pdu_seen = pdu_seen + 1'b1;
			if (pdu_left > 0) begin
				pdu_left = pdu_left - 1'b1;
			end
			step_q.push_back(make_result(KIND_PDU_BYTE, r, ST_OK, 8'h00, pdu_seen));
			if (pdu_left == 0) begin
				if (pdu_first == (req_func | EXC_FLAG)) begin
					step_q.push_back(make_result(KIND_STATUS, 8'h00, ST_EXCEPTION,
						(pdu_seen >= 2) ? pdu_second : 8'h00, pdu_seen));
				end else if (pdu_first != req_func) begin
					step_q.push_back(make_result(KIND_STATUS, 8'h00, ST_BAD_PDU, 8'h00, pdu_seen));
				end else begin
					step_q.push_back(make_result(KIND_STATUS, 8'h00, ST_OK, 8'h00, pdu_seen));
				end
				phase = PH_IDLE;
			end
		end
		if (step_q.size() > 0) begin
			step_q[step_q.size() - 1].fin = 1'b1;
		end
		foreach (step_q[i]) begin
			expected_results.push_back(step_q[i]);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic compare_result();
		framer_result_t want;
		result_count++;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result transaction, expected none, actual kind %0d byte %0d",
				$time, kind, out_byte);
			fail_count++;
		end else begin
			want = expected_results.pop_front();
			check_field("kind", 16'(want.kind), 16'(kind));
			check_field("out_byte", 16'(want.data), 16'(out_byte));
			check_field("last", 16'(want.fin), 16'(last));
			check_field("status", 16'(want.st), 16'(status));
			check_field("exc_code", 16'(want.exc), 16'(exc_code));
			check_field("pdu_count", 16'(want.count), 16'(pdu_count));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			txn_id     = '0;
			req_unit   = '0;
			req_func   = '0;
			phase      = PH_IDLE;
			hdr_idx    = '0;
			pdu_left   = '0;
			pdu_seen   = '0;
			pdu_first  = '0;
			pdu_second = '0;
			foreach (hdr_bytes[i]) begin
				hdr_bytes[i] = '0;
			end
			expected_results.delete();
		end else begin
			if (pop && !empty) begin
				compare_result();
			end
			if (push && !full) begin
				predict_framer(op, unit_id, function_code, start_address, quantity, write_value,
					rx_byte);
			end
		end
		pending = expected_results.size();
	end

endmodule

// File: dv/modbus_tcp_client_framer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus TCP client framer testbench
// Drives request, response byte and event transactions into the framer in
// random bursts, pops results with a random stall pattern and leaves all
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module modbus_tcp_client_framer_tb;

	import mtcf_pkg::*;

	localparam int unsigned CYCLE_LIMIT      = 600000;
	localparam int unsigned DRAIN_CYCLES     = 40;
	localparam int unsigned RANDOM_ITEMS     = 310;
	localparam int unsigned LONG_HOLD_CYCLES = 400;
	localparam int unsigned LONGEST_EXCHANGE = 6;
	localparam int unsigned HOLD_EXCHANGE    = 4;
	localparam int unsigned PAUSE_EXCHANGE   = 14;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [2:0]         op;
	logic [7:0]         unit_id;
	logic [7:0]         function_code;
	logic [15:0]        start_address;
	logic [15:0]        quantity;
	logic [15:0]        write_value;
	logic [7:0]         rx_byte;
	logic               empty;
	logic               pop;
	logic [1:0]         kind;
	logic [7:0]         out_byte;
	logic               last;
	logic [2:0]         status;
	logic [7:0]         exc_code;
	logic [COUNT_W-1:0] pdu_count;

	int fail_count;
	int pending;
	int result_count;
	int items_sent;
	int random_items;
	int burst_left;
	int cycle_count;
	bit long_hold_req;
	bit long_hold_done;

	modbus_tcp_client_framer #(
		.MAX_PDU(MAX_PDU_DEFAULT)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.unit_id      (unit_id),
		.function_code(function_code),
		.start_address(start_address),
		.quantity     (quantity),
		.write_value  (write_value),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.out_byte     (out_byte),
		.last         (last),
		.status       (status),
		.exc_code     (exc_code),
		.pdu_count    (pdu_count)
	);

	modbus_tcp_client_framer_checker #(
		.MAX_PDU(MAX_PDU_DEFAULT)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.unit_id      (unit_id),
		.function_code(function_code),
		.start_address(start_address),
		.quantity     (quantity),
		.write_value  (write_value),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.out_byte     (out_byte),
		.last         (last),
		.status       (status),
		.exc_code     (exc_code),
		.pdu_count    (pdu_count),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : receiver
		int pop_pct;
		int pattern_left;
		pop_pct        = 100;
		pattern_left   = 0;
		long_hold_done = 1'b0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				pop <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(8, 64);
				case ($urandom_range(0, 3))
					0:       pop_pct = 100;
					1:       pop_pct = 75;
					2:       pop_pct = 40;
					default: pop_pct = 10;
				endcase
			end
			pattern_left--;
			pop <= ($urandom_range(0, 99) < pop_pct);
		end
	end

	task automatic send_item(input logic [2:0] o, input logic [7:0] u, input logic [7:0] f,
			input logic [15:0] a, input logic [15:0] q, input logic [15:0] v,
			input logic [7:0] r);
		int gap;
		push          <= 1'b1;
		op            <= o;
		unit_id       <= u;
		function_code <= f;
		start_address <= a;
		quantity      <= q;
		write_value   <= v;
		rx_byte       <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 24);
			gap        = $urandom_range(0, 7);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_req(input logic [7:0] u, input logic [7:0] f, input logic [15:0] a,
			input logic [15:0] q, input logic [15:0] v);
		send_item(OP_REQUEST, u, f, a, q, v, 8'($urandom));
	endtask

	task automatic send_event(input logic [2:0] o);
		send_item(o, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] r);
		if ($urandom_range(0, 24) == 0) begin
			send_event(3'($urandom_range(OP_LINK_ERROR + 1, 3'h7)));
		end
		send_item(OP_RX_BYTE, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), r);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_supported();
		case ($urandom_range(0, 2))
			0:       return FC_READ_HOLDING;
			1:       return FC_READ_INPUT;
			default: return FC_WRITE_SINGLE;
		endcase
	endfunction

	task automatic random_exchange(input bit longest);
		logic [7:0]  fc;
		logic [7:0]  unit;
		logic [15:0] proto;
		logic [15:0] len;
		logic [7:0]  hdr [7];
		logic [7:0]  b;
		int          pdu_len;
		int          total;
		int          abort_at;
		bit          hdr_ok;
		if (longest || $urandom_range(0, 9) != 0) begin
			fc = pick_supported();
		end else begin
			do begin
				fc = 8'($urandom);
			end while (fc == FC_READ_HOLDING || fc == FC_READ_INPUT || fc == FC_WRITE_SINGLE);
		end
		case ($urandom_range(0, 5))
			0:       unit = 8'h00;
			1:       unit = 8'hFF;
			default: unit = 8'($urandom);
		endcase
		send_req(unit, fc, 16'($urandom), 16'($urandom), 16'($urandom));
		random_items++;
		if (fc != FC_READ_HOLDING && fc != FC_READ_INPUT && fc != FC_WRITE_SINGLE) begin
			return;
		end
		proto = ($urandom_range(0, 11) == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
		case ($urandom_range(0, 19))
			0:       len = 16'd0;
			1:       len = 16'd1;
			2:       len = 16'(MAX_PDU_DEFAULT + 2);
			3:       len = 16'($urandom_range(MAX_PDU_DEFAULT + 3, 16'hFFFF));
			default: len = 16'($urandom_range(2, 12));
		endcase
		hdr[6] = ($urandom_range(0, 11) == 0) ? unit ^ 8'($urandom_range(1, 255)) : unit;
		if (longest) begin
			proto  = 16'h0000;
			len    = 16'(MAX_PDU_DEFAULT + 1);
			hdr[6] = unit;
		end
		hdr[0]  = 8'($urandom);
		hdr[1]  = 8'($urandom);
		hdr[2]  = proto[15:8];
		hdr[3]  = proto[7:0];
		hdr[4]  = len[15:8];
		hdr[5]  = len[7:0];
		hdr_ok  = proto == 0 && len >= 2 && hdr[6] == unit && int'(len) - 1 <= MAX_PDU_DEFAULT;
		pdu_len = hdr_ok ? int'(len) - 1 : 0;
		total   = 7 + pdu_len;
		abort_at = (!longest && $urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : -1;
		for (int k = 0; k < total; k++) begin
			if (k == abort_at) begin
				if ($urandom_range(0, 2) == 0) begin
					send_req(8'($urandom), pick_supported(), 16'($urandom), 16'($urandom),
						16'($urandom));
				end else begin
					send_event(3'($urandom_range(OP_TIMEOUT, OP_LINK_ERROR)));
				end
				random_items++;
				return;
			end
			if (k < 7) begin
				b = hdr[k];
			end else if (k == 7) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: b = fc;
					6, 7:             b = fc | EXC_FLAG;
					default:          b = 8'($urandom);
				endcase
			end else begin
				b = 8'($urandom);
			end
			send_byte(b);
			random_items++;
		end
		if ($urandom_range(0, 9) == 0) begin
			send_byte(8'($urandom));
		end
	endtask

	initial begin : stimulus
		int exchanges;
		arst_n         <= 1'b0;
		push           <= 1'b0;
		op             <= OP_REQUEST;
		unit_id        <= '0;
		function_code  <= '0;
		start_address  <= '0;
		quantity       <= '0;
		write_value    <= '0;
		rx_byte        <= '0;
		long_hold_req  <= 1'b0;
		items_sent      = 0;
		random_items    = 0;
		burst_left      = 1;
		exchanges       = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Anything but a request is dropped while idle.
		send_event(OP_TIMEOUT);
		send_event(3'($urandom_range(OP_LINK_ERROR + 1, 3'h7)));
		send_byte(8'hFF);
		send_req(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
		// Write single with the shortest reply, carrying a one-byte exception.
		send_req(8'h00, FC_WRITE_SINGLE, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(FC_WRITE_SINGLE | EXC_FLAG);
		send_req(8'hFF, FC_READ_INPUT, 16'hFFFF, 16'h0000, 16'h0000);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h00);
		send_event(OP_LINK_ERROR);
		send_req(8'hA5, FC_READ_HOLDING, 16'h1234, 16'h0002, 16'h5555);
		send_event(OP_TIMEOUT);
		// A second request while one is pending drops the first.
		send_req(8'h5A, FC_READ_HOLDING, 16'h8000, 16'h007D, 16'h0000);
		send_req(8'h5A, FC_READ_INPUT, 16'h0001, 16'h0001, 16'hAAAA);
		send_event(OP_CLOSED);
		wait_drained();

		while (random_items < RANDOM_ITEMS) begin
			random_exchange(exchanges == LONGEST_EXCHANGE);
			exchanges++;
			if (exchanges == HOLD_EXCHANGE) begin
				long_hold_req <= 1'b1;
			end
			if (exchanges == PAUSE_EXCHANGE) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d input transactions (%0d random exchanges), checked %0d results.",
			items_sent, exchanges, result_count);
		$display("Exercised every operation, header faults, exceptions, aborts and a full PDU.");
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
